// File: sv/sfpm_pkg.sv
// Shared types, constants and helpers for the Sv32 fault page mapper.
// Used by every module of the block; depends on nothing else.
package sfpm_pkg;

  // Field widths fixed by the Sv32 format.
  localparam int unsigned PpnW    = 22;
  localparam int unsigned VpnW    = 10;
  localparam int unsigned AsidW   = 9;
  localparam int unsigned AddrW   = 34;
  localparam int unsigned WordW   = 32;
  localparam int unsigned PageCntW = PpnW + 1;
  localparam int unsigned CfgIdxW = 1;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepthDefault = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FIRST_FREE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_FREE  = 1'b1;

  // Reset values of the allocator.
  localparam logic [PageCntW-1:0] FirstFreeReset = 23'd1024;
  localparam logic [PpnW-1:0]     LastFreeReset  = 22'h3FFFFF;

  // Item modes and page fault cause codes.
  localparam logic       MODE_FAULT    = 1'b0;
  localparam logic       MODE_READ_RSP = 1'b1;
  localparam logic [4:0] CAUSE_INSN_PF  = 5'd12;
  localparam logic [4:0] CAUSE_LOAD_PF  = 5'd13;
  localparam logic [4:0] CAUSE_STORE_PF = 5'd15;

  // PTE flag positions and the low bits written into new PTEs.
  localparam int unsigned PteBitV = 0;
  localparam int unsigned PteBitR = 1;
  localparam int unsigned PteBitX = 3;
  localparam logic [9:0]  TableFlags = 10'h001;
  localparam logic [9:0]  LeafFlags  = 10'h0CF;

  typedef enum logic [2:0] {
    KIND_NOT_HANDLED = 3'd0,
    KIND_READ_REQ    = 3'd1,
    KIND_WRITE_REQ   = 3'd2,
    KIND_DONE        = 3'd3,
    KIND_LEAF_ERROR  = 3'd4,
    KIND_OUT_OF_PAGES = 3'd5,
    KIND_UNEXPECTED  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_L1   = 2'd1,
    PH_L0   = 2'd2
  } phase_t;

  // Result sequence that one command expands into.
  typedef enum logic [1:0] {
    SEQ_SINGLE      = 2'd0,
    SEQ_WR_DONE     = 2'd1,
    SEQ_WR_OOP      = 2'd2,
    SEQ_WR_WR_DONE  = 2'd3
  } seq_t;

  typedef struct packed {
    logic             mode;
    logic [4:0]       cause;
    logic [WordW-1:0] fault_address;
    logic [WordW-1:0] satp;
    logic [WordW-1:0] read_data;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [AddrW-1:0] mem_address;
    logic [WordW-1:0] write_data;
    logic [AsidW-1:0] flush_asid;
    logic [WordW-1:0] flush_vaddr;
    logic             last;
  } result_t;

  typedef struct packed {
    seq_t             seq;
    kind_t            kind;
    logic [AddrW-1:0] addr1;
    logic [WordW-1:0] data1;
    logic [AddrW-1:0] addr2;
    logic [WordW-1:0] data2;
    logic [AsidW-1:0] asid;
    logic [WordW-1:0] vaddr;
  } cmd_t;

  // Byte address of a PTE: page base plus index times four never carries.
  function automatic logic [AddrW-1:0] entry_byte_addr(logic [PpnW-1:0] ppn,
                                                       logic [VpnW-1:0] idx);
    return {ppn, idx, 2'b00};
  endfunction

endpackage

// File: sv/sfpm_front.sv
// Front part of the fault page mapper: accepts items, tracks the walk and allocates pages.
// Produces one command per accepted item for the back part. Depends on sfpm_pkg.
module sfpm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  sfpm_pkg::item_t                item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfpm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sfpm_pkg::PpnW-1:0]      cfg_data,
  input  logic                           queue_full,
  output logic                           push,
  output sfpm_pkg::cmd_t                 cmd
);
  import sfpm_pkg::*;

  phase_t                phase, phase_next;
  logic [WordW-1:0]      saved_vaddr, saved_vaddr_next;
  logic [AsidW-1:0]      saved_asid, saved_asid_next;
  logic [AddrW-1:0]      pending_addr, pending_addr_next;
  logic [PageCntW-1:0]   next_free_page, next_free_page_next;
  logic [PpnW-1:0]       last_free_ppn;

  logic                  accept;
  logic                  is_fault;
  logic                  pte_valid;
  logic                  pte_leaf;
  logic [VpnW-1:0]       vpn0;
  logic [PageCntW-1:0]   page_plus1;
  logic [PageCntW-1:0]   page_plus2;
  logic                  no_page0;
  logic                  no_page1;
  logic [AddrW-1:0]      table_leaf_addr;

  // Handshakes: the front stalls only when the queue has no room.
  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign push       = accept;
  assign cfg_ready  = 1'b1;

  // Classification of the current item.
  assign is_fault  = (item.cause == CAUSE_INSN_PF) || (item.cause == CAUSE_LOAD_PF) ||
                     (item.cause == CAUSE_STORE_PF);
  assign pte_valid = item.read_data[PteBitV];
  assign pte_leaf  = item.read_data[PteBitR] || item.read_data[PteBitX];
  assign vpn0      = saved_vaddr[12 +: VpnW];

  // Allocator checks for the first and, after a table page, the second page.
  assign page_plus1      = next_free_page + PageCntW'(1);
  assign page_plus2      = next_free_page + PageCntW'(2);
  assign no_page0        = next_free_page > {1'b0, last_free_ppn};
  assign no_page1        = page_plus1 > {1'b0, last_free_ppn};
  assign table_leaf_addr = entry_byte_addr(next_free_page[PpnW-1:0], vpn0);

  // Walk phase transitions.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (item.mode == MODE_FAULT && is_fault) phase_next = PH_L1;
        end
        PH_L1: begin
          if (item.mode == MODE_READ_RSP) phase_next = (pte_valid && !pte_leaf) ? PH_L0 : PH_IDLE;
        end
        PH_L0: begin
          if (item.mode == MODE_READ_RSP) phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Command for the back part and updates of the saved walk context.
  always_comb begin
    cmd                 = '0;
    cmd.seq             = SEQ_SINGLE;
    cmd.kind            = KIND_UNEXPECTED;
    cmd.asid            = saved_asid;
    cmd.vaddr           = saved_vaddr;
    saved_vaddr_next    = saved_vaddr;
    saved_asid_next     = saved_asid;
    pending_addr_next   = pending_addr;
    next_free_page_next = next_free_page;
    if (item.mode == MODE_FAULT) begin
      if (phase == PH_IDLE) begin
        if (!is_fault) begin
          cmd.kind = KIND_NOT_HANDLED;
        end else begin
          saved_vaddr_next  = item.fault_address;
          saved_asid_next   = item.satp[22 +: AsidW];
          pending_addr_next = entry_byte_addr(item.satp[PpnW-1:0],
                                              item.fault_address[22 +: VpnW]);
          cmd.kind          = KIND_READ_REQ;
          cmd.addr1         = pending_addr_next;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (pte_valid && pte_leaf) begin
        // A leaf at either level is an error.
        cmd.kind  = KIND_LEAF_ERROR;
        cmd.addr1 = pending_addr;
      end else if (phase == PH_L1 && pte_valid) begin
        // Descend into the existing level-0 table.
        pending_addr_next = entry_byte_addr(item.read_data[10 +: PpnW], vpn0);
        cmd.kind          = KIND_READ_REQ;
        cmd.addr1         = pending_addr_next;
      end else if (phase == PH_L1) begin
        // Missing level-1 entry: allocate a table page, then the data page.
        if (no_page0) begin
          cmd.kind = KIND_OUT_OF_PAGES;
        end else begin
          cmd.addr1         = pending_addr;
          cmd.data1         = {next_free_page[PpnW-1:0], TableFlags};
          pending_addr_next = table_leaf_addr;
          if (no_page1) begin
            cmd.seq             = SEQ_WR_OOP;
            next_free_page_next = page_plus1;
          end else begin
            cmd.seq             = SEQ_WR_WR_DONE;
            cmd.addr2           = table_leaf_addr;
            cmd.data2           = {page_plus1[PpnW-1:0], LeafFlags};
            next_free_page_next = page_plus2;
          end
        end
      end else begin
        // Level 0: write the leaf over an invalid or non-leaf entry.
        if (no_page0) begin
          cmd.kind = KIND_OUT_OF_PAGES;
        end else begin
          cmd.seq             = SEQ_WR_DONE;
          cmd.addr1           = pending_addr;
          cmd.data1           = {next_free_page[PpnW-1:0], LeafFlags};
          next_free_page_next = page_plus1;
        end
      end
    end
  end

  // Control state and allocator registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      saved_vaddr    <= '0;
      saved_asid     <= '0;
      pending_addr   <= '0;
      next_free_page <= FirstFreeReset;
      last_free_ppn  <= LastFreeReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIRST_FREE) next_free_page <= {1'b0, cfg_data};
      if (cfg_index == CFG_LAST_FREE)  last_free_ppn  <= cfg_data;
    end else if (accept) begin
      phase          <= phase_next;
      saved_vaddr    <= saved_vaddr_next;
      saved_asid     <= saved_asid_next;
      pending_addr   <= pending_addr_next;
      next_free_page <= next_free_page_next;
    end
  end

`ifndef SYNTHESIS
  // A walk can only start from idle with a page fault cause.
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !(item.mode == MODE_FAULT && is_fault) |=> phase == PH_IDLE)
    else $error("walk started without a page fault");
  // Level 0 is reached only from level 1.
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE |=> phase != PH_L0)
    else $error("level 0 entered from idle");
  // Every page handed out lies within the allocator range.
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.seq != SEQ_SINGLE) |-> !no_page0)
    else $error("page written beyond the allocator range");
`endif

endmodule

// File: sv/sfpm_queue.sv
// Command queue between the front and back parts of the fault page mapper.
// Register array with a read pointer, a write pointer and a fill count. Depends on sfpm_pkg.
module sfpm_queue #(
  parameter int unsigned Depth = sfpm_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfpm_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output sfpm_pkg::cmd_t  head_cmd
);
  import sfpm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t              entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_pop;

  assign full       = count == CntW'(Depth);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !do_pop) count <= count + CntW'(1);
      else if (do_pop && !push) count <= count - CntW'(1);
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst) count <= CntW'(Depth))
    else $error("queue count beyond depth");
  // A push alone into an empty queue leaves exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    push && !do_pop && count == '0 |=> count == CntW'(1))
    else $error("queue lost an entry");
  // Pointers meet only when the queue is empty or full.
  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (count == '0 || full))
    else $error("queue pointers out of step with count");
`endif

endmodule

// File: sv/sfpm_back.sv
// Back part of the fault page mapper: a command register and a step counter expand each
// command into its result transactions, one per cycle unless stalled. Depends on sfpm_pkg.
module sfpm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sfpm_pkg::cmd_t     head_cmd,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output sfpm_pkg::result_t  result
);
  import sfpm_pkg::*;

  cmd_t        cur;
  logic        busy;
  logic [1:0]  step;
  logic        take;
  logic        item_done;
  logic        load;

  assign result_valid = busy;
  assign take         = busy && !result_stall;
  assign item_done    = take && result.last;
  assign load         = !busy || item_done;
  assign pop          = load && head_valid;

  // Result decoder for the current command and step.
  always_comb begin
    result      = '0;
    result.kind = KIND_NOT_HANDLED;
    unique case (cur.seq)
      SEQ_SINGLE: begin
        result.kind        = cur.kind;
        result.mem_address = cur.addr1;
        result.last        = 1'b1;
      end
      SEQ_WR_DONE: begin
        if (step == 2'd0) begin
          result.kind        = KIND_WRITE_REQ;
          result.mem_address = cur.addr1;
          result.write_data  = cur.data1;
        end else begin
          result.kind        = KIND_DONE;
          result.flush_asid  = cur.asid;
          result.flush_vaddr = cur.vaddr;
          result.last        = 1'b1;
        end
      end
      SEQ_WR_OOP: begin
        if (step == 2'd0) begin
          result.kind        = KIND_WRITE_REQ;
          result.mem_address = cur.addr1;
          result.write_data  = cur.data1;
        end else begin
          result.kind = KIND_OUT_OF_PAGES;
          result.last = 1'b1;
        end
      end
      SEQ_WR_WR_DONE: begin
        if (step == 2'd0) begin
          result.kind        = KIND_WRITE_REQ;
          result.mem_address = cur.addr1;
          result.write_data  = cur.data1;
        end else if (step == 2'd1) begin
          result.kind        = KIND_WRITE_REQ;
          result.mem_address = cur.addr2;
          result.write_data  = cur.data2;
        end else begin
          result.kind        = KIND_DONE;
          result.flush_asid  = cur.asid;
          result.flush_vaddr = cur.vaddr;
          result.last        = 1'b1;
        end
      end
      default: result.last = 1'b1;
    endcase
  end

  // Command register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (pop) cur <= head_cmd;
  end

  // Busy flag and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= head_valid;
      step <= '0;
    end else if (take) begin
      step <= step + 2'd1;
    end
  end

`ifndef SYNTHESIS
  // A single-result command never advances past its first step.
  assert property (@(posedge clk) disable iff (rst)
    busy && cur.seq == SEQ_SINGLE |-> step == 2'd0)
    else $error("single command advanced");
  // Two-result commands stop at their second step.
  assert property (@(posedge clk) disable iff (rst)
    busy && (cur.seq == SEQ_WR_DONE || cur.seq == SEQ_WR_OOP) |-> step <= 2'd1)
    else $error("two-result command overran");
  // A result that is not the last of its item is followed by another.
  assert property (@(posedge clk) disable iff (rst)
    take && !result.last |=> result_valid)
    else $error("item ended without its last result");
`endif

endmodule

// File: sv/sv32_fault_page_mapper_unit.sv
// Top level of the Sv32 fault page mapper: front, command queue and back.
// Depends on sfpm_pkg, sfpm_front, sfpm_queue and sfpm_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   item     | in        | item_valid/stall   | item_t: mode, cause, address, satp, data
//   result   | out       | result_valid/stall | result_t: kind, address, data, flush
//   cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data (22-bit PPN)
//
// An item is accepted whenever the command queue has room; its results, one to three per
// item, leave the back part one per cycle while result_stall is low, so the result port sets
// the sustained rate. Each command passes through the command queue and then the back
// part's command register before its first result is valid.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds; the front keeps accepting until QueueDepth commands wait.
module sv32_fault_page_mapper_unit #(
  parameter int unsigned QueueDepth = sfpm_pkg::QueueDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  sfpm_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output sfpm_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfpm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfpm_pkg::PpnW-1:0]     cfg_data
);
  import sfpm_pkg::*;

  logic  queue_full;
  logic  push;
  cmd_t  push_cmd;
  logic  pop;
  logic  head_valid;
  cmd_t  head_cmd;

  // Front: classification, walk state and page allocation.
  sfpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Queue that decouples the two sides.
  sfpm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: result transactions, one per cycle unless stalled.
  sfpm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: bench/sfpm_walk_checker.sv
// Checker for the Sv32 fault page mapper: watches the item, result and register channels.
// It predicts every result of each accepted item and compares them in order.
// Depends on sfpm_pkg for the payload types, codes and PTE flag constants.
module sfpm_walk_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  sfpm_pkg::item_t               item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  sfpm_pkg::result_t             result,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sfpm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfpm_pkg::PpnW-1:0]     cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);
  import sfpm_pkg::*;

  // Allocator registers and the walk state as the block should hold them.
  logic [PpnW-1:0]     alloc_limit;
  logic [PageCntW-1:0] alloc_next;
  phase_t              phase;
  logic [WordW-1:0]    fault_va;
  logic [AsidW-1:0]    fault_asid;
  logic [AddrW-1:0]    pte_ptr;

  // Results still owed by the block, oldest first.
  result_t     expected_results[$];
  int unsigned errors = 0;

  assign fail_count = errors;

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Byte address of entry idx in the page numbered ppn.
  function automatic logic [AddrW-1:0] entry_addr(logic [PpnW-1:0] ppn,
                                                  logic [VpnW-1:0] idx);
    return ({12'd0, ppn} << 12) + {22'd0, idx, 2'b00};
  endfunction

  // Hands out the next free page unless the counter has passed the limit.
  function automatic bit grab_page(output logic [PpnW-1:0] ppn);
    ppn = '0;
    if (alloc_next > {1'b0, alloc_limit}) begin
      return 1'b0;
    end
    ppn = alloc_next[PpnW-1:0];
    alloc_next = alloc_next + 1'b1;
    return 1'b1;
  endfunction

  function automatic void add_result(kind_t k, logic [AddrW-1:0] addr,
                                     logic [WordW-1:0] data, logic [AsidW-1:0] asid,
                                     logic [WordW-1:0] vaddr);
    result_t r;
    r.kind        = k;
    r.mem_address = addr;
    r.write_data  = data;
    r.flush_asid  = asid;
    r.flush_vaddr = vaddr;
    r.last        = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Allocates the data page, writes its leaf entry into slot and reports done, or reports out of pages.
  function automatic void map_data_page(logic [AddrW-1:0] slot);
    logic [PpnW-1:0] ppn;
    if (!grab_page(ppn)) begin
      add_result(KIND_OUT_OF_PAGES, '0, '0, '0, '0);
      return;
    end
    add_result(KIND_WRITE_REQ, slot, {ppn, LeafFlags}, '0, '0);
    add_result(KIND_DONE, '0, '0, fault_asid, fault_va);
  endfunction

  // Advances the walk by one item and queues the results it causes.
  function automatic void predict_walk(item_t it);
    logic [PpnW-1:0] table_ppn;
    logic [VpnW-1:0] vpn0;
    logic            pte_v;
    logic            pte_leaf;
    logic            busy;
    result_t         tail;
    busy     = (phase != PH_IDLE);
    vpn0     = fault_va[21:12];
    pte_v    = it.read_data[PteBitV];
    pte_leaf = it.read_data[PteBitR] | it.read_data[PteBitX];
    if (it.mode == MODE_FAULT) begin
      if (busy) begin
        add_result(KIND_UNEXPECTED, '0, '0, '0, '0);
      end else if (it.cause != CAUSE_INSN_PF && it.cause != CAUSE_LOAD_PF &&
                   it.cause != CAUSE_STORE_PF) begin
        add_result(KIND_NOT_HANDLED, '0, '0, '0, '0);
      end else begin
        fault_va   = it.fault_address;
        fault_asid = it.satp[30:22];
        pte_ptr    = entry_addr(it.satp[21:0], it.fault_address[31:22]);
        phase      = PH_L1;
        add_result(KIND_READ_REQ, pte_ptr, '0, '0, '0);
      end
    end else if (!busy) begin
      add_result(KIND_UNEXPECTED, '0, '0, '0, '0);
    end else if (pte_v && pte_leaf) begin
      // A mapping already exists, so the walk gives up.
      phase = PH_IDLE;
      add_result(KIND_LEAF_ERROR, pte_ptr, '0, '0, '0);
    end else if (phase == PH_L1) begin
      if (pte_v) begin
        pte_ptr = entry_addr(it.read_data[31:10], vpn0);
        phase   = PH_L0;
        add_result(KIND_READ_REQ, pte_ptr, '0, '0, '0);
      end else begin
        // Missing second-level table: the new one is taken as zeroed and never read.
        phase = PH_IDLE;
        if (!grab_page(table_ppn)) begin
          add_result(KIND_OUT_OF_PAGES, '0, '0, '0, '0);
        end else begin
          add_result(KIND_WRITE_REQ, pte_ptr, {table_ppn, TableFlags}, '0, '0);
          pte_ptr = entry_addr(table_ppn, vpn0);
          map_data_page(pte_ptr);
        end
      end
    end else begin
      // Invalid or non-leaf entry at the second level is replaced by the new leaf.
      phase = PH_IDLE;
      map_data_page(pte_ptr);
    end
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result with nothing expected: kind %0d addr %h data %h",
                             got.kind, got.mem_address, got.write_data));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind || got.mem_address !== want.mem_address ||
        got.write_data !== want.write_data || got.flush_asid !== want.flush_asid ||
        got.flush_vaddr !== want.flush_vaddr || got.last !== want.last) begin
      note_failure($sformatf(
        "result mismatch: expected kind %0d addr %h data %h asid %h va %h last %b",
        want.kind, want.mem_address, want.write_data, want.flush_asid,
        want.flush_vaddr, want.last));
      if (errors <= 10) begin
        $display("                   got kind %0d addr %h data %h asid %h va %h last %b",
                 got.kind, got.mem_address, got.write_data, got.flush_asid,
                 got.flush_vaddr, got.last);
      end
    end
  endfunction

  // Results are checked before the same edge's item so that an early result is caught.
  always @(posedge clk) begin
    if (rst) begin
      alloc_limit = LastFreeReset;
      alloc_next  = FirstFreeReset;
      phase       = PH_IDLE;
      fault_va    = '0;
      fault_asid  = '0;
      pte_ptr     = '0;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_FREE) begin
          alloc_next = {1'b0, cfg_data};
        end else if (cfg_index == CFG_LAST_FREE) begin
          alloc_limit = cfg_data;
        end
      end
      if (item_valid && !item_stall) begin
        predict_walk(item);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: bench/sv32_fault_page_mapper_unit_test.sv
// Testbench top for the Sv32 fault page mapper: clock, reset, stimulus and verdict.
// Depends on sfpm_pkg, the block sv32_fault_page_mapper_unit and sfpm_walk_checker.
module sv32_fault_page_mapper_unit_test;
  import sfpm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  item_t              item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CFG_FIRST_FREE;
  logic [PpnW-1:0]    cfg_data = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sv32_fault_page_mapper_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sfpm_walk_checker walk_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Free-running cycle count and the run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // The result side stalls with a varying density, and once holds off for a long stretch.
  initial begin : result_sink
    int unsigned stall_pct;
    int unsigned span;
    forever begin
      span = $urandom_range(60, 20);
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          result_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
        end
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic item_t fault_at(logic [4:0] cause, logic [WordW-1:0] vaddr,
                                     logic [WordW-1:0] satp_word);
    item_t it;
    it.mode          = MODE_FAULT;
    it.cause         = cause;
    it.fault_address = vaddr;
    it.satp          = satp_word;
    it.read_data     = $urandom;
    return it;
  endfunction

  function automatic item_t reply(logic [WordW-1:0] word);
    item_t it;
    it.mode          = MODE_READ_RSP;
    it.cause         = 5'($urandom_range(31));
    it.fault_address = $urandom;
    it.satp          = $urandom;
    it.read_data     = word;
    return it;
  endfunction

  // Random PTE word with the valid bit and the leaf bits chosen.
  function automatic logic [WordW-1:0] pte_word(bit v, bit leaf);
    logic [WordW-1:0] w;
    w = $urandom;
    w[PteBitV] = v;
    if (leaf) begin
      case ($urandom_range(2))
        0: w[PteBitR] = 1'b1;
        1: w[PteBitX] = 1'b1;
        default: begin
          w[PteBitR] = 1'b1;
          w[PteBitX] = 1'b1;
        end
      endcase
    end else begin
      w[PteBitR] = 1'b0;
      w[PteBitX] = 1'b0;
    end
    return w;
  endfunction

  function automatic logic [4:0] page_fault_cause();
    case ($urandom_range(2))
      0: return CAUSE_INSN_PF;
      1: return CAUSE_LOAD_PF;
      default: return CAUSE_STORE_PF;
    endcase
  endfunction

  // Offers one item until the block takes the transaction, then maybe idles.
  task automatic send_item(item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
        burst_left = $urandom_range(10, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high across both register writes and drops after the second one.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PpnW-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic [PpnW-1:0] first_ppn, logic [PpnW-1:0] last_ppn);
    write_reg(CFG_FIRST_FREE, first_ppn);
    write_reg(CFG_LAST_FREE, last_ppn);
    cfg_valid <= 1'b0;
  endtask

  // One complete walk with random content, sometimes with a stray fault inside it.
  task automatic random_walk();
    int unsigned pick;
    send_item(fault_at(page_fault_cause(), $urandom, $urandom));
    if ($urandom_range(9) == 0) begin
      send_item(fault_at(5'($urandom_range(31)), $urandom, $urandom));
    end
    pick = $urandom_range(9);
    if (pick < 2) begin
      send_item(reply(pte_word(1'b1, 1'b1)));
    end else if (pick < 6) begin
      send_item(reply(pte_word(1'b0, 1'($urandom_range(1)))));
    end else begin
      send_item(reply(pte_word(1'b1, 1'b0)));
      if ($urandom_range(9) == 0) begin
        send_item(fault_at(5'($urandom_range(31)), $urandom, $urandom));
      end
      pick = $urandom_range(9);
      if (pick < 2) begin
        send_item(reply(pte_word(1'b1, 1'b1)));
      end else if (pick < 4) begin
        send_item(reply(pte_word(1'b1, 1'b0)));
      end else begin
        send_item(reply(pte_word(1'b0, 1'($urandom_range(1)))));
      end
    end
  endtask

  // Items outside a walk: a read response while idle or a cause that is not a page fault.
  task automatic stray_item();
    logic [4:0] cause;
    if ($urandom_range(1) == 1) begin
      send_item(reply($urandom));
    end else begin
      do cause = 5'($urandom_range(31));
      while (cause == CAUSE_INSN_PF || cause == CAUSE_LOAD_PF || cause == CAUSE_STORE_PF);
      send_item(fault_at(cause, $urandom, $urandom));
    end
  endtask

  task automatic random_run(int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) begin
      steady = ($urandom_range(5) == 0);
      if ($urandom_range(4) == 0) begin
        stray_item();
      end else begin
        random_walk();
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [PpnW-1:0] base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Missing top-level entry with zero address and satp: table and data page allocated.
    send_item(fault_at(CAUSE_INSN_PF, 32'h0000_0000, 32'h0000_0000));
    send_item(reply(32'h0000_0000));
    // All-ones address and satp, pointer to the highest page, then a leaf at level 0.
    send_item(fault_at(CAUSE_LOAD_PF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(reply(32'hFFFF_FC01));
    send_item(reply(32'hFFFF_FFFF));
    // Leaf already present at the top level.
    send_item(fault_at(CAUSE_STORE_PF, 32'h1234_5678, 32'h8040_0010));
    send_item(reply(32'h0000_000B));
    // A valid non-leaf entry at level 0 gets overwritten.
    send_item(fault_at(CAUSE_INSN_PF, 32'hABCD_E000, 32'h7FFF_FFFF));
    send_item(reply(32'h0012_3401));
    send_item(reply(32'h5555_5401));
    // Invalid entry at level 0 with every other bit set: only a data page is needed.
    send_item(fault_at(CAUSE_LOAD_PF, $urandom, $urandom));
    send_item(reply(32'h0000_0401));
    send_item(reply(32'hFFFF_FFFE));
    // Causes that are not page faults.
    send_item(fault_at(5'd0, $urandom, $urandom));
    send_item(fault_at(5'd31, $urandom, $urandom));
    send_item(fault_at(5'd14, $urandom, $urandom));
    // Read response with no walk in progress.
    send_item(reply(32'hFFFF_FFFF));
    // A second fault while a walk is in progress.
    send_item(fault_at(CAUSE_STORE_PF, $urandom, $urandom));
    send_item(fault_at(CAUSE_INSN_PF, $urandom, $urandom));
    send_item(reply(32'h0000_0000));
    settle();

    // Single page available: the table takes it and the data page runs out.
    configure(22'd0, 22'd0);
    send_item(fault_at(CAUSE_STORE_PF, $urandom, $urandom));
    send_item(reply(32'h0000_0000));
    send_item(fault_at(CAUSE_LOAD_PF, $urandom, $urandom));
    send_item(reply(32'h0000_0401));
    send_item(reply(32'h0000_0000));
    settle();

    // Highest page number only; the long hold-off on results fills the block up.
    configure(22'h3F_FFFF, 22'h3F_FFFF);
    hold_request = 1'b1;
    steady = 1'b1;
    repeat (6) random_walk();
    steady = 1'b0;
    random_run(35);
    settle();

    // Narrow random window of pages, so the allocator runs dry during the run.
    base = 22'($urandom_range(22'h3F_FFC0));
    configure(base, base + 22'($urandom_range(40)));
    random_run(50);
    settle();

    // Random start with the full range above it.
    configure(22'($urandom_range(22'h3F_FFFF)), 22'h3F_FFFF);
    random_run(50);
    settle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
